[rtl/ogeu_pkg.sv]
package ogeu_pkg;

  localparam int GRID_DIM    = 128;
  localparam int IDX_W       = $clog2(GRID_DIM);
  localparam int CELLS       = GRID_DIM * GRID_DIM;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int CONF_W      = 10;
  localparam int LIM_W       = 8;
  localparam int COORD_W     = 16;
  localparam int OUT_IDX_W   = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic {
    CMD_MARK   = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_RISE   = 3'd2,
    REG_FALL   = 3'd3,
    REG_CEIL   = 3'd4,
    REG_THRESH = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [LIM_W-1:0]  rows_in_use;
    logic [LIM_W-1:0]  cols_in_use;
    logic [CONF_W-1:0] rise_step;
    logic [CONF_W-1:0] fall_step;
    logic [CONF_W-1:0] ceiling;
    logic [CONF_W-1:0] report_threshold;
  } cfg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } entry_t;

  typedef struct packed {
    logic [CONF_W-1:0]    confidence;
    logic [OUT_IDX_W-1:0] col;
    logic [OUT_IDX_W-1:0] row;
  } result_t;

endpackage

[rtl/ogeu_cfg_regs.sv]
module ogeu_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ogeu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ogeu_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ogeu_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output ogeu_pkg::cfg_t                   cfg
);
  import ogeu_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_in_use      <= LIM_W'(100);
      cfg_r.cols_in_use      <= LIM_W'(100);
      cfg_r.rise_step        <= CONF_W'(5);
      cfg_r.fall_step        <= CONF_W'(2);
      cfg_r.ceiling          <= CONF_W'(1000);
      cfg_r.report_threshold <= CONF_W'(10);
    end else if (wr_en) begin
      unique case (idx)
        REG_ROWS:   cfg_r.rows_in_use      <= pwdata[LIM_W-1:0];
        REG_COLS:   cfg_r.cols_in_use      <= pwdata[LIM_W-1:0];
        REG_RISE:   cfg_r.rise_step        <= pwdata[CONF_W-1:0];
        REG_FALL:   cfg_r.fall_step        <= pwdata[CONF_W-1:0];
        REG_CEIL:   cfg_r.ceiling          <= pwdata[CONF_W-1:0];
        REG_THRESH: cfg_r.report_threshold <= pwdata[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ROWS:   prdata = CFG_DATA_W'(cfg_r.rows_in_use);
      REG_COLS:   prdata = CFG_DATA_W'(cfg_r.cols_in_use);
      REG_RISE:   prdata = CFG_DATA_W'(cfg_r.rise_step);
      REG_FALL:   prdata = CFG_DATA_W'(cfg_r.fall_step);
      REG_CEIL:   prdata = CFG_DATA_W'(cfg_r.ceiling);
      REG_THRESH: prdata = CFG_DATA_W'(cfg_r.report_threshold);
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/ogeu_front.sv]
module ogeu_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,
  input  logic                          in_tuser,
  input  ogeu_pkg::cfg_t                cfg,
  input  logic                          clearing,
  input  logic                          q_full,
  output logic                          q_push,
  output ogeu_pkg::entry_t              q_entry
);
  import ogeu_pkg::*;

  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic               x_ok;
  logic               y_ok;
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   col;

  assign x = in_tdata[COORD_W-1:0];
  assign y = in_tdata[2*COORD_W-1:COORD_W];

  // A set sign bit means a negative coordinate, which is always out of range.
  assign x_ok = !x[COORD_W-1] && (x < COORD_W'(cfg.rows_in_use)) && (x < COORD_W'(GRID_DIM));
  assign y_ok = !y[COORD_W-1] && (y < COORD_W'(cfg.cols_in_use)) && (y < COORD_W'(GRID_DIM));

  assign row = x[IDX_W-1:0];
  assign col = y[IDX_W-1:0];

  assign in_tready = !clearing && !q_full;
  // Out-of-range beats are taken and dropped here.
  assign q_push    = in_tvalid && in_tready && x_ok && y_ok;

  always_comb begin
    q_entry.cmd  = cmd_t'(in_tuser);
    q_entry.row  = row;
    q_entry.col  = col;
    q_entry.addr = ADDR_W'(32'(row) * GRID_DIM + 32'(col));
  end

endmodule

[rtl/ogeu_queue.sv]
module ogeu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ogeu_pkg::entry_t  push_entry,
  input  logic              pop,
  output ogeu_pkg::entry_t  head,
  output logic              empty,
  output logic              full
);
  import ogeu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/ogeu_back.sv]
module ogeu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ogeu_pkg::cfg_t     cfg,
  input  ogeu_pkg::entry_t   head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output ogeu_pkg::result_t  out_res
);
  import ogeu_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPLY
  } state_t;

  logic              mark_mem [CELLS];
  logic [CONF_W-1:0] conf_mem [CELLS];

  state_t            state_r;
  logic [ADDR_W-1:0] clr_addr_r;
  entry_t            cur_r;
  logic              out_valid_r;
  result_t           out_res_r;
  logic              rd_mark_r;
  logic [CONF_W-1:0] rd_conf_r;

  logic              rd_en;
  logic              out_free;
  logic              commit;
  logic              report;
  logic [CONF_W:0]   sum;
  logic [CONF_W-1:0] low;
  logic [CONF_W-1:0] new_conf;
  logic              mark_we;
  logic              mark_wd;
  logic              conf_we;
  logic [CONF_W-1:0] conf_wd;
  logic [ADDR_W-1:0] mem_addr;

  assign clearing  = (state_r == ST_CLEAR);
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign rd_en     = q_pop && (head.cmd == CMD_UPDATE);
  assign out_free  = !out_valid_r || out_ready;
  assign commit    = (state_r == ST_APPLY) && out_free;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Saturate at zero first, then at the ceiling, so a lowered ceiling pulls the count down.
  always_comb begin
    sum = {1'b0, rd_conf_r} + {1'b0, cfg.rise_step};
    low = (cfg.fall_step > rd_conf_r) ? '0 : rd_conf_r - cfg.fall_step;
    if (rd_mark_r) begin
      new_conf = (sum > {1'b0, cfg.ceiling}) ? cfg.ceiling : sum[CONF_W-1:0];
    end else begin
      new_conf = (low > cfg.ceiling) ? cfg.ceiling : low;
    end
    report = (new_conf >= cfg.report_threshold);
  end

  always_comb begin
    mark_we  = 1'b0;
    mark_wd  = 1'b0;
    conf_we  = 1'b0;
    conf_wd  = '0;
    mem_addr = head.addr;
    unique case (state_r)
      ST_CLEAR: begin
        mark_we  = 1'b1;
        conf_we  = 1'b1;
        mem_addr = clr_addr_r;
      end
      ST_IDLE: begin
        mark_we  = q_pop && (head.cmd == CMD_MARK);
        mark_wd  = 1'b1;
        mem_addr = head.addr;
      end
      ST_APPLY: begin
        mark_we  = commit;
        conf_we  = commit;
        conf_wd  = new_conf;
        mem_addr = cur_r.addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mem_addr] <= mark_wd;
    end
    if (rd_en) begin
      rd_mark_r <= mark_mem[head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (conf_we) begin
      conf_mem[mem_addr] <= conf_wd;
    end
    if (rd_en) begin
      rd_conf_r <= conf_mem[head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !(commit && report)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (rd_en) begin
            cur_r   <= head;
            state_r <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (commit) begin
            state_r <= ST_IDLE;
            if (report) begin
              out_valid_r          <= 1'b1;
              out_res_r.row        <= OUT_IDX_W'(cur_r.row);
              out_res_r.col        <= OUT_IDX_W'(cur_r.col);
              out_res_r.confidence <= new_conf;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/occupancy_grid_evidence_update_unit.sv]
// Occupancy grid evidence accumulator over a 128 x 128 cell memory. After reset the block
// clears every cell in a sweep, one cell per cycle, and holds in_tready low meanwhile;
// configuration writes are taken throughout. The front end accepts one beat per cycle
// while the queue has room, into a four-entry queue, dropping out-of-range points at once.
// The back end drains the queue: a mark beat is a single write of the mark memory, an update
// beat a read of the cell, then the write-back of count and mark, which waits while an
// earlier result is still held for out_tready. The next beat is popped only after that
// write-back, as the read-modify-write of the single-ported cell memory requires.
module occupancy_grid_evidence_update_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // x_coord[15:0], y_coord[31:16]
  input  logic                             in_tuser,   // cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // row[6:0], col[13:7], confidence[23:14]
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ogeu_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ogeu_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ogeu_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import ogeu_pkg::*;

  cfg_t    cfg;
  entry_t  q_entry;
  entry_t  q_head;
  result_t out_res;
  logic    q_push;
  logic    q_pop;
  logic    q_empty;
  logic    q_full;
  logic    clearing;

  ogeu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ogeu_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  ogeu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  ogeu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res;

  // No beat may slip in while the cell memory is still being swept.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !clearing)
    else $error("input beat accepted during clearing sweep");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_tvalid)
    else $error("result presented during clearing sweep");

  a_queue_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> !q_empty)
    else $error("queue empty after a push without pop");

endmodule

[sim/occupancy_grid_evidence_update_unit_tb.sv]
`timescale 1ns / 100ps

module occupancy_grid_evidence_update_unit_tb;
  import ogeu_pkg::*;

  typedef struct {
    cmd_t               cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } grid_point_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata    = '0;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [23:0]           out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  occupancy_grid_evidence_update_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow copy of the grid and of the register file.
  bit [CONF_W-1:0] confidence_grid [CELLS];
  bit              mark_grid [CELLS];
  int rows_lim    = 100;
  int cols_lim    = 100;
  int rise_amt    = 5;
  int fall_amt    = 2;
  int ceiling_lvl = 1000;
  int report_lvl  = 10;

  grid_point_t pending_points [$];
  result_t     pending_reports [$];
  grid_point_t held_point;
  result_t     seen_report;
  result_t     want_report;

  int total_points    = 0;
  int accepted_points = 0;
  int fault_count     = 0;
  int in_idle_pct     = 0;
  int out_stall_pct   = 0;
  int in_gap          = 0;
  int out_stall       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int cap_limit(int lim);
    return (lim > GRID_DIM) ? GRID_DIM : lim;
  endfunction

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pressure();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 20;
      default: return 60;
    endcase
  endfunction

  // Works out what one accepted beat does to the grid and what it reports.
  function automatic void apply_evidence(cmd_t cmd, logic signed [15:0] x,
                                         logic signed [15:0] y);
    int      idx;
    int      level;
    result_t rep;
    if (x < 0 || y < 0) return;
    if (x >= cap_limit(rows_lim) || y >= cap_limit(cols_lim)) return;
    idx = x * GRID_DIM + y;
    if (cmd == CMD_MARK) begin
      mark_grid[idx] = 1'b1;
      return;
    end
    level = confidence_grid[idx];
    if (mark_grid[idx]) level += rise_amt;
    else level -= fall_amt;
    // Floor first, then the ceiling, so a lowered ceiling always wins.
    if (level < 0) level = 0;
    if (level > ceiling_lvl) level = ceiling_lvl;
    confidence_grid[idx] = CONF_W'(level);
    mark_grid[idx] = 1'b0;
    if (level < report_lvl) return;
    rep.row        = x[OUT_IDX_W-1:0];
    rep.col        = y[OUT_IDX_W-1:0];
    rep.confidence = CONF_W'(level);
    pending_reports.insert(pending_reports.size(), rep);
  endfunction

  task automatic report_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Input driver: a new beat is loaded only once the previous one has gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_evidence(held_point.cmd, held_point.x, held_point.y);
        accepted_points++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          held_point = pending_points.pop_front();
          in_tvalid  <= 1'b1;
          in_tdata   <= {held_point.y, held_point.x};
          in_tuser   <= held_point.cmd;
          in_gap     = pick_gap(in_idle_pct);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_report = result_t'(out_tdata);
        if (pending_reports.size() == 0) begin
          report_fault($sformatf("unexpected report row %0d col %0d confidence %0d",
                                 seen_report.row, seen_report.col, seen_report.confidence));
        end else begin
          want_report = pending_reports.pop_front();
          if (seen_report.row !== want_report.row || seen_report.col !== want_report.col ||
              seen_report.confidence !== want_report.confidence)
            report_fault($sformatf({"report mismatch: row exp %0d got %0d, col exp %0d got %0d,",
                                    " confidence exp %0d got %0d"},
                                   want_report.row, seen_report.row,
                                   want_report.col, seen_report.col,
                                   want_report.confidence, seen_report.confidence));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall  = pick_gap(out_stall_pct);
      end
    end
  end

  task automatic write_reg(reg_idx_t r, int unsigned value);
    logic [CFG_DATA_W-1:0] word;
    word = value;
    // Bits above every register's width must be ignored.
    if ($urandom_range(0, 3) == 0) word[31:16] = 16'($urandom());
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(4 * r);
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (r)
      REG_ROWS:   rows_lim    = word[LIM_W-1:0];
      REG_COLS:   cols_lim    = word[LIM_W-1:0];
      REG_RISE:   rise_amt    = word[CONF_W-1:0];
      REG_FALL:   fall_amt    = word[CONF_W-1:0];
      REG_CEIL:   ceiling_lvl = word[CONF_W-1:0];
      REG_THRESH: report_lvl  = word[CONF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic add_point(cmd_t cmd, logic signed [15:0] x, logic signed [15:0] y);
    grid_point_t p;
    p.cmd = cmd;
    p.x   = x;
    p.y   = y;
    pending_points.insert(pending_points.size(), p);
    total_points++;
  endtask

  function automatic logic signed [15:0] pick_coord(int lim);
    int roll;
    roll = $urandom_range(0, 99);
    if (lim > 0 && roll < 88) return 16'($urandom_range(0, lim - 1));
    if (roll < 93) return 16'(lim + $urandom_range(0, 3));
    if (roll < 97) return 16'(-int'($urandom_range(1, 4)));
    return 16'($urandom());
  endfunction

  // A host-style sweep over a handful of cells: mark lists, then updates.
  task automatic add_sweep(int ncells, int rounds);
    logic signed [15:0] xs [8];
    logic signed [15:0] ys [8];
    int                 off;
    for (int k = 0; k < ncells; k++) begin
      xs[k] = pick_coord(cap_limit(rows_lim));
      ys[k] = pick_coord(cap_limit(cols_lim));
    end
    for (int r = 0; r < rounds; r++) begin
      for (int k = 0; k < ncells; k++)
        repeat ($urandom_range(0, 2)) add_point(CMD_MARK, xs[k], ys[k]);
      if ($urandom_range(0, 9) == 0)
        add_point(cmd_t'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()));
      // Now and then a round's updates never come, leaving marks behind.
      if ($urandom_range(0, 9) != 0) begin
        off = $urandom_range(0, ncells - 1);
        for (int k = 0; k < ncells; k++)
          add_point(CMD_UPDATE, xs[(k + off) % ncells], ys[(k + off) % ncells]);
      end
    end
  endtask

  task automatic add_random_points(int n);
    int stop;
    stop = total_points + n;
    while (total_points < stop) begin
      if ($urandom_range(0, 9) != 0)
        add_sweep($urandom_range(1, 8), $urandom_range(1, 5));
      else
        add_point(cmd_t'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()));
    end
  endtask

  // Waits until every beat has gone in and every report has come out.
  task automatic settle();
    int guard;
    guard = 0;
    while (accepted_points < total_points) @(posedge clk);
    while (pending_reports.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_reports.size() != 0) begin
      report_fault($sformatf("%0d reports never arrived", pending_reports.size()));
      fault_count += pending_reports.size() - 1;
      pending_reports.delete();
    end
    // Mark beats leave no report, so let the back end finish its queue.
    repeat (16) @(posedge clk);
  endtask

  task automatic run_phase(int rows, int cols, int rise, int fall, int ceil_v, int thr, int n);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    write_reg(REG_RISE, rise);
    write_reg(REG_FALL, fall);
    write_reg(REG_CEIL, ceil_v);
    write_reg(REG_THRESH, thr);
    in_idle_pct   = pick_pressure();
    out_stall_pct = pick_pressure();
    add_random_points(n);
    settle();
  endtask

  function automatic int pick_limit();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return $urandom_range(1, 10);
    if (roll < 9) return $urandom_range(11, 128);
    return $urandom_range(129, 255);
  endfunction

  initial begin
    int ceil_pick;
    int thr_pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset configuration.
    add_point(CMD_UPDATE, 0, 0);
    add_point(CMD_MARK, 0, 0);
    add_point(CMD_UPDATE, 0, 0);
    add_point(CMD_MARK, 0, 0);
    add_point(CMD_MARK, 0, 0);
    add_point(CMD_UPDATE, 0, 0);
    add_point(CMD_UPDATE, 0, 0);
    add_point(CMD_MARK, 99, 99);
    add_point(CMD_UPDATE, 99, 99);
    add_point(CMD_MARK, 100, 5);
    add_point(CMD_UPDATE, 100, 5);
    add_point(CMD_MARK, 5, 100);
    add_point(CMD_UPDATE, 5, 100);
    add_point(CMD_MARK, -1, 3);
    add_point(CMD_UPDATE, 3, -1);
    add_point(CMD_UPDATE, -32768, -32768);
    add_point(CMD_MARK, 32767, 32767);
    add_point(CMD_UPDATE, -1, -1);
    add_point(CMD_MARK, 0, 99);
    add_point(CMD_UPDATE, 0, 99);
    add_point(CMD_MARK, 99, 0);
    add_point(CMD_UPDATE, 99, 0);
    settle();

    run_phase(4, 4, 300, 100, 1023, 0, 150);
    // The ceiling drops below counts built up just before.
    run_phase(4, 4, 1023, 0, 50, 50, 120);
    run_phase(255, 200, 0, 1023, 1023, 0, 150);
    run_phase(0, 128, 7, 3, 600, 20, 40);
    run_phase(1, 1, 1, 1, 1023, 1, 80);
    run_phase(128, 128, 512, 1, 1023, 1023, 120);
    run_phase(2, 3, 0, 0, 0, 0, 60);

    while (total_points < 1080) begin
      ceil_pick = $urandom_range(0, 1023);
      thr_pick  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, ceil_pick);
      run_phase(pick_limit(), pick_limit(), $urandom_range(0, 1023) >> $urandom_range(0, 6),
                $urandom_range(0, 1023) >> $urandom_range(0, 6), ceil_pick, thr_pick, 120);
    end

    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
